// File: rtl/csvt_pkg.sv
package csvt_pkg;

	// Special characters of the text stream
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// Parser states
	localparam logic [2:0] MODE_START  = 3'd0;
	localparam logic [2:0] MODE_PLAIN  = 3'd1;
	localparam logic [2:0] MODE_QUOTED = 3'd2;
	localparam logic [2:0] MODE_QSEEN  = 3'd3;
	localparam logic [2:0] MODE_IGNORE = 3'd4;

	// Result kinds
	localparam logic [1:0] KIND_BYTE      = 2'd0;
	localparam logic [1:0] KIND_FIELD_END = 2'd1;
	localparam logic [1:0] KIND_ROW_END   = 2'd2;

	// Configuration register indexes
	localparam logic CFG_COLUMN_LIMIT = 1'b0;
	localparam logic CFG_LINE_LIMIT   = 1'b1;

	localparam logic [10:0] COLUMN_LIMIT_RST = 11'd300;
	localparam logic [15:0] LINE_LIMIT_RST   = 16'd8192;

	// One result word
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic [10:0] column;
	} res_t;

	// Results caused by one input byte
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} res_pair_t;

	// Queue entry
	typedef struct packed {
		res_t res;
		logic last;
	} qent_t;

endpackage

// File: rtl/csvt_parser.sv
module csvt_parser
	import csvt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        accept,
	input  logic [7:0]  data_byte,
	output res_pair_t   results
);

	logic [10:0] column_limit_q;
	logic [15:0] line_limit_q;
	logic [2:0]  mode_q;
	logic [10:0] col_q;
	logic [15:0] row_len_q;
	logic        started_q;

	logic [2:0]  mode_d;
	logic [10:0] col_d;
	logic [15:0] row_len_d;
	logic        started_d;
	logic [15:0] cap;
	logic [11:0] lim;
	logic [11:0] col_inc;
	res_pair_t   res;

	// Hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_limit_q <= COLUMN_LIMIT_RST;
			line_limit_q   <= LINE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COLUMN_LIMIT: column_limit_q <= cfg_data[10:0];
				CFG_LINE_LIMIT:   line_limit_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cap     = (line_limit_q == 16'd0) ? 16'd0 : line_limit_q - 16'd1;
	assign lim     = (column_limit_q == 11'd0) ? 12'd1 : {1'b0, column_limit_q};
	assign col_inc = {1'b0, col_q} + 12'd1;

	// Decode one byte against the parser state
	always_comb begin
		mode_d    = mode_q;
		col_d     = col_q;
		row_len_d = row_len_q;
		started_d = started_q;
		res       = '0;
		if (data_byte == CH_CR) begin
			// drop carriage returns
		end else if (data_byte == CH_LF) begin
			if (started_q) begin
				if (mode_q != MODE_IGNORE) begin
					res.n  = 2'd2;
					res.r0 = '{kind: KIND_FIELD_END, data: 8'd0, column: col_q};
					res.r1 = '{kind: KIND_ROW_END, data: 8'd0, column: col_inc[10:0]};
				end else begin
					res.n  = 2'd1;
					res.r0 = '{kind: KIND_ROW_END, data: 8'd0, column: col_inc[10:0]};
				end
			end
			mode_d    = MODE_START;
			col_d     = '0;
			row_len_d = '0;
			started_d = 1'b0;
		end else if (row_len_q < cap) begin
			row_len_d = row_len_q + 16'd1;
			started_d = 1'b1;
			unique case (mode_q) inside
				MODE_START, MODE_PLAIN, MODE_QSEEN: begin
					if (data_byte == CH_COMMA) begin
						// close the field, go on or stop at the column limit
						res.n  = 2'd1;
						res.r0 = '{kind: KIND_FIELD_END, data: 8'd0, column: col_q};
						if (col_inc >= lim) begin
							mode_d = MODE_IGNORE;
						end else begin
							col_d  = col_inc[10:0];
							mode_d = MODE_START;
						end
					end else if (mode_q == MODE_START && data_byte == CH_QUOTE) begin
						mode_d = MODE_QUOTED;
					end else if (mode_q == MODE_QSEEN && data_byte == CH_QUOTE) begin
						res.n  = 2'd2;
						res.r0 = '{kind: KIND_BYTE, data: CH_QUOTE, column: col_q};
						res.r1 = '{kind: KIND_BYTE, data: CH_QUOTE, column: col_q};
						mode_d = MODE_QUOTED;
					end else if (mode_q == MODE_QSEEN) begin
						res.n  = 2'd1;
						res.r0 = '{kind: KIND_FIELD_END, data: 8'd0, column: col_q};
						mode_d = MODE_IGNORE;
					end else begin
						res.n  = 2'd1;
						res.r0 = '{kind: KIND_BYTE, data: data_byte, column: col_q};
						mode_d = MODE_PLAIN;
					end
				end
				MODE_QUOTED: begin
					if (data_byte == CH_QUOTE) begin
						mode_d = MODE_QSEEN;
					end else begin
						res.n  = 2'd1;
						res.r0 = '{kind: KIND_BYTE, data: data_byte, column: col_q};
					end
				end
				default: mode_d = MODE_IGNORE;
			endcase
		end
	end

	assign results = res;

	// Advance the parser state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_START;
			col_q     <= '0;
			row_len_q <= '0;
			started_q <= 1'b0;
		end else if (accept) begin
			mode_q    <= mode_d;
			col_q     <= col_d;
			row_len_q <= row_len_d;
			started_q <= started_d;
		end
	end

	a_idle_row_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!started_q |-> (mode_q == MODE_START && col_q == 11'd0 && row_len_q == 16'd0))
		else $error("row not started but parser state dirty");

	a_ignore_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_IGNORE |-> started_q)
		else $error("ignore state outside a row");

	a_lf_resets_row: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && data_byte == CH_LF) |=> (!started_q && row_len_q == 16'd0))
		else $error("newline did not reset the row");

endmodule

// File: rtl/csvt_outq.sv
module csvt_outq
	import csvt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  res_pair_t results,
	output logic      room,
	output logic      out_valid,
	input  logic      out_ready,
	output qent_t     out_ent
);

	localparam int DEPTH = 4;

	qent_t      ent_q [DEPTH];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;
	logic [1:0] push_n;
	logic       pop;

	assign push_n    = push ? results.n : 2'd0;
	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != 3'd0);
	assign out_ent   = ent_q[rd_ptr_q];
	// leave space for the largest result pair
	assign room      = (count_q <= 3'd2);

	// Store the results of one byte, marking the final one
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			ent_q[wr_ptr_q] <= '{res: results.r0, last: (push_n == 2'd1)};
		end
		if (push_n == 2'd2) begin
			ent_q[wr_ptr_q + 2'd1] <= '{res: results.r1, last: 1'b1};
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + {1'b0, push_n} - {2'b00, pop};
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'(DEPTH))
		else $error("output queue overflow");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q == $past(count_q) + {1'b0, $past(push_n)} - {2'b00, $past(pop)})
		else $error("fill count mismatch");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != 3'(DEPTH)) |-> (wr_ptr_q - rd_ptr_q) == count_q[1:0])
		else $error("queue pointers disagree with fill count");

endmodule

// File: rtl/csv_field_tokenizer.sv
// CSV field tokenizer.
// Input stream: one raw text byte per word on s_tdata. Output stream: one
// result word per field content byte, field end or row end; m_tuser carries
// the kind (0 content byte, 1 field end, 2 row end), m_tdata the byte and
// the column, m_tlast marks the final result caused by one input byte.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 column limit, 1 line limit); write only while the block is idle.
// Results of a taken byte are written into the 4-entry output queue and leave
// it in order. Throughput: one byte per cycle while the queue has room; the
// output drains one word per cycle while m_tready is high, so a byte that gives
// two results (row end, doubled quote) uses the single output port twice.
// The input stays ready while at most two words wait in the queue, so a
// stalled receiver backs up the input once three or four words wait.
// Reset: clears the parser to the start of a row, empties the queue and
// loads the column limit 300 and line limit 8192.
module csv_field_tokenizer
	import csvt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] out_byte, [18:8] column, [23:19] zero
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast
);

	res_pair_t results;
	qent_t     head;
	logic      accept;

	assign accept = s_tvalid && s_tready;

	// Decode bytes into results
	csvt_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.data_byte (s_tdata),
		.results   (results)
	);

	// Queue results toward the receiver
	csvt_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.results   (results),
		.room      (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_ent   (head)
	);

	assign m_tdata = {5'd0, head.res.column, head.res.data};
	assign m_tuser = head.res.kind;
	assign m_tlast = head.last;

endmodule

// File: tb/csv_field_tokenizer_check.sv
module csv_field_tokenizer_check
	import csvt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending_words
);
	timeunit 1ns;
	timeprecision 1ps;

	// Parser copy and its settings
	logic [2:0]  mode;
	logic [10:0] field_col;
	logic [15:0] row_len;
	logic        row_open;
	logic [10:0] col_limit;
	logic [15:0] line_limit;

	// Words caused by the byte at hand, and all words still owed by the block
	res_t  byte_words[$];
	qent_t expected_words[$];

	initial begin
		fail_count = 0;
		pending_words = 0;
	end

	task automatic report(input string msg);
		$display("%0t ns: token mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic note_word(input logic [1:0] kind, input logic [7:0] data,
		input logic [10:0] column);
		res_t r;
		r.kind = kind;
		r.data = data;
		r.column = column;
		byte_words.push_back(r);
	endtask

	// Close the field at a comma: advance to the next one, or ignore the rest of the row at the limit
	task automatic close_at_comma();
		int lim;
		lim = (col_limit == 11'd0) ? 1 : int'(col_limit);
		note_word(KIND_FIELD_END, 8'h00, field_col);
		if (int'(field_col) + 1 >= lim) begin
			mode = MODE_IGNORE;
		end else begin
			field_col = field_col + 11'd1;
			mode = MODE_START;
		end
	endtask

	// Split one text byte and queue the words it causes
	task automatic tokenize_byte(input logic [7:0] c);
		int cap;
		qent_t ent;
		byte_words.delete();
		cap = (line_limit == 16'd0) ? 0 : int'(line_limit) - 1;
		if (c == CH_CR)
			return;
		if (c == CH_LF) begin
			if (row_open) begin
				if (mode != MODE_IGNORE)
					note_word(KIND_FIELD_END, 8'h00, field_col);
				note_word(KIND_ROW_END, 8'h00, field_col + 11'd1);
			end
			mode = MODE_START;
			field_col = 11'd0;
			row_len = 16'd0;
			row_open = 1'b0;
		end else if (int'(row_len) < cap) begin
			row_len = row_len + 16'd1;
			row_open = 1'b1;
			case (mode)
				MODE_START: begin
					if (c == CH_QUOTE) begin
						mode = MODE_QUOTED;
					end else if (c == CH_COMMA) begin
						close_at_comma();
					end else begin
						mode = MODE_PLAIN;
						note_word(KIND_BYTE, c, field_col);
					end
				end
				MODE_PLAIN: begin
					if (c == CH_COMMA)
						close_at_comma();
					else
						note_word(KIND_BYTE, c, field_col);
				end
				MODE_QUOTED: begin
					if (c == CH_QUOTE)
						mode = MODE_QSEEN;
					else
						note_word(KIND_BYTE, c, field_col);
				end
				MODE_QSEEN: begin
					if (c == CH_QUOTE) begin
						note_word(KIND_BYTE, CH_QUOTE, field_col);
						note_word(KIND_BYTE, CH_QUOTE, field_col);
						mode = MODE_QUOTED;
					end else if (c == CH_COMMA) begin
						close_at_comma();
					end else begin
						// a closing quote not followed by a comma ends the columns
						note_word(KIND_FIELD_END, 8'h00, field_col);
						mode = MODE_IGNORE;
					end
				end
				default: mode = MODE_IGNORE;
			endcase
		end
		for (int i = 0; i < byte_words.size(); i++) begin
			ent.res = byte_words[i];
			ent.last = (i == byte_words.size() - 1);
			expected_words.push_back(ent);
		end
	endtask

	// Compare one output word with the oldest expectation
	task automatic check_word();
		qent_t want;
		if (expected_words.size() == 0) begin
			report($sformatf("word kind %0d byte %0h column %0d with nothing pending",
				m_tuser, m_tdata[7:0], m_tdata[18:8]));
			return;
		end
		want = expected_words.pop_front();
		if (m_tuser !== want.res.kind)
			report($sformatf("kind got %0d want %0d", m_tuser, want.res.kind));
		if (m_tdata[7:0] !== want.res.data)
			report($sformatf("byte got %0h want %0h", m_tdata[7:0], want.res.data));
		if (m_tdata[18:8] !== want.res.column)
			report($sformatf("column got %0d want %0d", m_tdata[18:8], want.res.column));
		if (m_tdata[23:19] !== 5'd0)
			report($sformatf("pad bits got %0h want 0", m_tdata[23:19]));
		if (m_tlast !== want.last)
			report($sformatf("last got %0b want %0b", m_tlast, want.last));
	endtask

	// Track settings, check output words, predict from input words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = MODE_START;
			field_col = 11'd0;
			row_len = 16'd0;
			row_open = 1'b0;
			col_limit = COLUMN_LIMIT_RST;
			line_limit = LINE_LIMIT_RST;
			expected_words.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_COLUMN_LIMIT: col_limit = cfg_data[10:0];
					CFG_LINE_LIMIT:   line_limit = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready)
				check_word();
			if (s_tvalid && s_tready)
				tokenize_byte(s_tdata);
		end
		pending_words = expected_words.size();
	end

endmodule

// File: tb/csv_field_tokenizer_test.sv
module csv_field_tokenizer_test;
	import csvt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 300000;
	localparam int ITEMS_PER_PHASE = 140;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = 16'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	int fail_count;
	int pending_words;
	int sent_count = 0;
	int cycle_count = 0;
	logic calm;

	// No idling on either side inside this window of items
	assign calm = (sent_count >= 600) && (sent_count < 800);

	csv_field_tokenizer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	csv_field_tokenizer_check i_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast),
		.fail_count   (fail_count),
		.pending_words(pending_words)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Receiver: random stalls, one long hold-off, a calm window
	initial begin
		bit held;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && sent_count >= 300) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (200) @(posedge clk);
			end
			m_tready <= calm || ($urandom_range(99) >= 23);
		end
	end

	// Offer one word and hold it until taken; valid stays high afterwards
	task automatic send_byte(input logic [7:0] b);
		if (!calm && $urandom_range(99) < 23) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 23);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		if (b != CH_CR)
			sent_count++;
	endtask

	task automatic send_text(input string txt);
		for (int i = 0; i < txt.len(); i++)
			send_byte(txt[i]);
	endtask

	// Drop valid and wait until every owed word has come out
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending_words != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limits(input logic [10:0] col, input logic [15:0] line);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_COLUMN_LIMIT;
		cfg_data <= {5'($urandom), col};
		@(posedge clk);
		cfg_index <= CFG_LINE_LIMIT;
		cfg_data <= line;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] field_byte(input bit quoted);
		logic [7:0] b;
		do b = 8'($urandom_range(255));
		while (b == CH_LF || b == CH_QUOTE || (!quoted && b == CH_COMMA));
		return b;
	endfunction

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(5))
			0: return CH_QUOTE;
			1: return CH_COMMA;
			2: return CH_CR;
			3: return CH_LF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Mostly well-formed rows with random content, some noise and broken quoting
	task automatic send_row();
		int n_fields;
		int len;
		if ($urandom_range(9) == 0) begin
			len = $urandom_range(1, 12);
			repeat (len) send_byte(noise_byte());
			if ($urandom_range(1) == 1)
				send_byte(CH_LF);
			return;
		end
		n_fields = $urandom_range(1, 6);
		for (int f = 0; f < n_fields; f++) begin
			if (f > 0)
				send_byte(CH_COMMA);
			len = $urandom_range(0, 5);
			if ($urandom_range(2) == 0) begin
				send_byte(CH_QUOTE);
				repeat (len) begin
					if ($urandom_range(5) == 0) begin
						send_byte(CH_QUOTE);
						send_byte(CH_QUOTE);
					end else begin
						send_byte(field_byte(1'b1));
					end
				end
				// unterminated quote now and then
				if ($urandom_range(11) != 0)
					send_byte(CH_QUOTE);
				if ($urandom_range(7) == 0)
					send_byte(field_byte(1'b0));
			end else begin
				repeat (len) send_byte(field_byte(1'b0));
			end
		end
		if ($urandom_range(3) == 0)
			send_byte(CH_CR);
		send_byte(CH_LF);
	endtask

	// Stimulus and verdict
	initial begin
		logic [10:0] col_set [8];
		logic [15:0] line_set [8];
		int start;
		col_set = '{11'd3, 11'd1, 11'd2047, 11'd5, 11'd300, 11'd1024, 11'd2, 11'd8};
		line_set = '{16'd8192, 16'd6, 16'd65535, 16'd3, 16'd2, 16'd65535, 16'd12, 16'd20};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: zero and 0xFF bytes, carriage return, empty row
		send_byte(8'h00);
		send_byte(CH_COMMA);
		send_byte(8'hFF);
		send_byte(CH_CR);
		send_byte(CH_LF);
		send_byte(CH_LF);
		// Quote dropped, doubled quote kept, closing quote then junk
		send_text("\"a\"\"b\",\"c\"x\n");
		// Row ends inside a quoted field
		send_text("\"q\n");

		// Zero column limit acts as one; row end while ignoring
		set_limits(11'd0, 16'd8192);
		send_text("a,b,c\n");
		// Tiny line limits store nothing
		set_limits(11'd2, 16'd1);
		send_text("ab,c\n");
		set_limits(11'd2, 16'd0);
		send_text("x\n");
		// Bytes past the line limit are dropped
		set_limits(11'd2, 16'd4);
		send_text("abcdef\n");

		// Random rows under a range of settings
		for (int p = 0; p < 8; p++) begin
			set_limits(col_set[p], line_set[p]);
			start = sent_count;
			while (sent_count - start < ITEMS_PER_PHASE)
				send_row();
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending_words == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/csvt_pkg.sv
rtl/csvt_parser.sv
rtl/csvt_outq.sv
rtl/csv_field_tokenizer.sv
tb/csv_field_tokenizer_check.sv
tb/csv_field_tokenizer_test.sv
